// ===== sv/bpa_pkg.sv =====
// shared types and constants of the bitmap page allocator
`timescale 1ns / 1ps
package bpa_pkg;

  // page numbers follow the 11-bit page total
  localparam int PAGE_W  = 11;
  localparam int FIELD_W = 10;
  // one map word covers a lane of eight pages
  localparam int LANE_W  = 8;
  localparam int LANE_LG = 3;
  localparam int WIDX_W  = PAGE_W - LANE_LG;

  // operation codes
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // register index of the page total
  localparam logic REG_TOTAL_PAGES = 1'b0;
  localparam logic [PAGE_W-1:0] TOTAL_RESET = 11'd1024;

  typedef struct packed {
    logic               kind;
    logic [PAGE_W-1:0]  page_count;
    logic [FIELD_W-1:0] start_page;
  } bpa_cmd_t;

  typedef struct packed {
    logic               success;
    logic [FIELD_W-1:0] first_page;
  } bpa_result_t;

  // free run being tracked by the scan
  typedef struct packed {
    logic [PAGE_W-1:0] len;
    logic [PAGE_W-1:0] start;
  } bpa_run_t;

  typedef struct packed {
    bpa_run_t run;
    logic     found;
    logic     exhausted;
  } bpa_scan_t;

endpackage

// ===== sv/bpa_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bpa_lane_unit.sv =====
// shared scan unit: runs the first-fit search over one map word
`timescale 1ns / 1ps
module bpa_lane_unit (
  input  logic [bpa_pkg::LANE_W-1:0] word,
  input  logic [bpa_pkg::WIDX_W-1:0] widx,
  input  bpa_pkg::bpa_run_t          run_in,
  input  logic [bpa_pkg::PAGE_W-1:0] count,
  input  logic [bpa_pkg::PAGE_W-1:0] total,
  output bpa_pkg::bpa_scan_t         res
);
  import bpa_pkg::*;

  logic [PAGE_W:0] next_base;

  // first page after this word
  assign next_base = {1'b0, widx, {LANE_LG{1'b1}}} + (PAGE_W+1)'(1);

  // walk the eight pages of the word, extending or breaking the run
  always_comb begin
    logic [PAGE_W-1:0] len;
    logic [PAGE_W-1:0] st;
    logic [PAGE_W-1:0] p;
    logic              found;
    logic              past;
    len   = run_in.len;
    st    = run_in.start;
    found = 1'b0;
    past  = 1'b0;
    for (int b = 0; b < LANE_W; b++) begin
      p = {widx, LANE_LG'(b)};
      if (!found && !past) begin
        if (p >= total) begin
          past = 1'b1;
        end else if (p != '0 && !word[b]) begin
          if (len == '0) begin
            st = p;
          end
          len = len + 1'b1;
          if (len == count) begin
            found = 1'b1;
          end
        end else begin
          len = '0;
        end
      end
    end
    res.run.len   = len;
    res.run.start = st;
    res.found     = found;
    res.exhausted = past || (next_base >= {1'b0, total});
  end

endmodule

// ===== sv/bitmap_page_allocator_top.sv =====
// top level of the bitmap page allocator: sequencer, config register, used-page map
`timescale 1ns / 1ps
// First-fit page allocator over a used-page bitmap held in a ram of 8-page words. A
// command word is taken when start is high and busy is low; its result word appears on
// result for exactly one cycle with done high and cannot be held off. After reset the
// block clears the map with busy high; the page total register may be written meanwhile.
// An allocate scans one map word per cycle through the shared lane unit, streaming reads
// from the ram until a run is found or the page total is passed, then reads and then
// writes each map word the run touches. A free likewise reads and then writes each map
// word it clears; a zero count or out-of-range free, or a zero-count allocate, is
// answered from idle without touching the map. The single ram read port sets this order.
module bitmap_page_allocator_top #(
  parameter int MAX_PAGES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  bpa_pkg::bpa_cmd_t    cmd,
  output logic                 done,
  output bpa_pkg::bpa_result_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bpa_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + LANE_W - 1) / LANE_W;
  localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PAGE_MAX  = (1 << PAGE_W) - 1;
  localparam int CAP_PAGES = (MAX_PAGES > PAGE_MAX) ? PAGE_MAX : MAX_PAGES;

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_MARK_RD = 5'b01000,
    ST_MARK_WR = 5'b10000
  } state_t;

  state_t              state;
  logic [PAGE_W-1:0]   total_pages;
  logic [PAGE_W-1:0]   act_total;
  logic                cfg_wr;
  logic                kind_r;
  logic [PAGE_W-1:0]   count_r;
  bpa_run_t            run;
  bpa_scan_t           scan;
  logic [WIDX_W-1:0]   rd_widx;
  logic                ev_valid;
  logic [WIDX_W-1:0]   ev_widx;
  logic [PAGE_W-1:0]   lo;
  logic [PAGE_W:0]     hi_ex;
  logic [PAGE_W:0]     hi_last;
  logic [WIDX_W-1:0]   mk_w;
  logic [WIDX_W-1:0]   last_w;
  logic [MAP_AW-1:0]   clr_addr;
  logic [PAGE_W-1:0]   start_ext;
  logic [PAGE_W:0]     free_end;
  logic [PAGE_W:0]     free_hi;
  logic [LANE_W-1:0]   mark_mask;
  logic                ram_we;
  logic [MAP_AW-1:0]   ram_waddr;
  logic [LANE_W-1:0]   ram_wdata;
  logic [MAP_AW-1:0]   ram_raddr;
  logic [LANE_W-1:0]   ram_rdata;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOTAL_PAGES);
  assign prdata = (paddr[2] == REG_TOTAL_PAGES) ? 32'(total_pages) : '0;

  // page total clipped to map capacity
  assign act_total = (total_pages > PAGE_W'(CAP_PAGES)) ? PAGE_W'(CAP_PAGES) : total_pages;

  assign busy = (state != ST_IDLE);

  // free range, clipped at the page total
  assign start_ext = PAGE_W'(cmd.start_page);
  assign free_end  = {1'b0, start_ext} + {1'b0, cmd.page_count};
  assign free_hi   = (free_end > {1'b0, act_total}) ? {1'b0, act_total} : free_end;

  // last map word touched by the mark or clear
  assign hi_last = hi_ex - (PAGE_W+1)'(1);
  assign last_w  = hi_last[PAGE_W-1:LANE_LG];

  // pages of the current word that lie inside the run
  always_comb begin
    logic [PAGE_W-1:0] p;
    for (int b = 0; b < LANE_W; b++) begin
      p = {mk_w, LANE_LG'(b)};
      mark_mask[b] = (p >= lo) && ({1'b0, p} < hi_ex);
    end
  end

  // map ram port steering
  assign ram_we    = (state == ST_CLEAR) || (state == ST_MARK_WR);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : MAP_AW'(mk_w);
  assign ram_wdata = (state == ST_CLEAR)   ? '0 :
                     (kind_r == KIND_ALLOC) ? (ram_rdata | mark_mask) :
                                              (ram_rdata & ~mark_mask);
  assign ram_raddr = (state == ST_SCAN) ? MAP_AW'(rd_widx) : MAP_AW'(mk_w);

  bpa_ram #(
    .WIDTH(LANE_W),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bpa_lane_unit u_lane (
    .word  (ram_rdata),
    .widx  (ev_widx),
    .run_in(run),
    .count (count_r),
    .total (act_total),
    .res   (scan)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      done        <= 1'b0;
      ev_valid    <= 1'b0;
      total_pages <= TOTAL_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        total_pages <= pwdata[PAGE_W-1:0];
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == MAP_AW'(MAP_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            kind_r  <= cmd.kind;
            count_r <= cmd.page_count;
            if (cmd.kind == KIND_ALLOC) begin
              if (cmd.page_count == '0) begin
                done   <= 1'b1;
                result <= '0;
              end else begin
                rd_widx  <= '0;
                ev_valid <= 1'b0;
                run      <= '0;
                state    <= ST_SCAN;
              end
            end else begin
              if (start_ext >= act_total) begin
                done   <= 1'b1;
                result <= '0;
              end else if (cmd.page_count == '0) begin
                done              <= 1'b1;
                result.success    <= 1'b1;
                result.first_page <= '0;
              end else begin
                lo    <= start_ext;
                hi_ex <= free_hi;
                mk_w  <= start_ext[PAGE_W-1:LANE_LG];
                state <= ST_MARK_RD;
              end
            end
          end
        end
        ST_SCAN: begin
          // reads run one word ahead of the lane unit
          rd_widx  <= rd_widx + 1'b1;
          ev_valid <= 1'b1;
          ev_widx  <= rd_widx;
          if (ev_valid) begin
            run <= scan.run;
            if (scan.found) begin
              lo    <= scan.run.start;
              hi_ex <= {1'b0, scan.run.start} + {1'b0, count_r};
              mk_w  <= scan.run.start[PAGE_W-1:LANE_LG];
              state <= ST_MARK_RD;
            end else if (scan.exhausted) begin
              done   <= 1'b1;
              result <= '0;
              state  <= ST_IDLE;
            end
          end
        end
        ST_MARK_RD: begin
          state <= ST_MARK_WR;
        end
        ST_MARK_WR: begin
          if (mk_w == last_w) begin
            done              <= 1'b1;
            result.success    <= 1'b1;
            result.first_page <= (kind_r == KIND_ALLOC) ? lo[FIELD_W-1:0] : '0;
            state             <= ST_IDLE;
          end else begin
            mk_w  <= mk_w + 1'b1;
            state <= ST_MARK_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // an accepted word either occupies the block or is answered at once
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("accepted word neither started nor answered");

  // a non-zero first page only comes with a successful allocate
  assert property (@(posedge clk) disable iff (rst)
    (done && (result.first_page != '0)) |-> result.success)
    else $error("first page given on a failed or free result");

  // every word written back holds at least one page of the run
  assert property (@(posedge clk) disable iff (rst) (state == ST_MARK_WR) |-> (mark_mask != '0))
    else $error("map word written with an empty mask");

  // no result while the map is still being cleared
  assert property (@(posedge clk) disable iff (rst) $past(state == ST_CLEAR) |-> !done)
    else $error("result during clearing pass");

endmodule

// ===== tb/bitmap_page_allocator_top_test.sv =====
// self-checking testbench for the bitmap page allocator top level
`timescale 1ns / 1ps
module bitmap_page_allocator_top_test;
  import bpa_pkg::*;

  localparam int MAX_PAGES = 1024;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 46;
  localparam logic [2:0] TOTAL_ADDR = {REG_TOTAL_PAGES, 2'b00};

  // page map mirror, prediction and result checking
  class page_map_checker;
    bit used_map [MAX_PAGES];
    logic [PAGE_W-1:0] total_pages;
    bpa_result_t awaited [$];
    int mismatches;

    function new();
      total_pages = TOTAL_RESET;
      mismatches = 0;
      foreach (used_map[i]) used_map[i] = 1'b0;
    endfunction

    // first-fit placement of an allocate, or clearing of a free
    function bpa_result_t place_or_release(bpa_cmd_t c);
      bpa_result_t r;
      int lim;
      int run_first;
      int run_len;
      int p;
      r = '0;
      lim = (int'(total_pages) > MAX_PAGES) ? MAX_PAGES : int'(total_pages);
      if (c.kind == KIND_ALLOC) begin
        run_first = 0;
        run_len = 0;
        if (c.page_count != '0) begin
          for (p = 1; p < lim && !r.success; p++) begin
            if (!used_map[p]) begin
              if (run_len == 0) run_first = p;
              run_len++;
              if (run_len == int'(c.page_count)) r.success = 1'b1;
            end else begin
              run_len = 0;
            end
          end
        end
        if (r.success) begin
          for (p = run_first; p < run_first + run_len; p++) used_map[p] = 1'b1;
          r.first_page = run_first[FIELD_W-1:0];
        end
      end else if (int'(c.start_page) < lim) begin
        // pages at or beyond the total are left alone
        for (p = int'(c.start_page);
             p < int'(c.start_page) + int'(c.page_count) && p < lim; p++)
          used_map[p] = 1'b0;
        r.success = 1'b1;
      end
      return r;
    endfunction

    function bpa_result_t note_cmd(bpa_cmd_t c);
      bpa_result_t r;
      r = place_or_release(c);
      awaited.push_back(r);
      return r;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(bpa_result_t got);
      bpa_result_t want;
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("result word with nothing awaited: %0d/%0d",
                                got.success, got.first_page));
      end else begin
        want = awaited.pop_front();
        if (got.success !== want.success)
          flag_mismatch($sformatf("success %0b, predicted %0b", got.success, want.success));
        if (got.first_page !== want.first_page)
          flag_mismatch($sformatf("first_page %0d, predicted %0d",
                                  got.first_page, want.first_page));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bpa_cmd_t cmd = '0;
  logic done;
  bpa_result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  page_map_checker sb = new();
  int stall_cycles = 0;
  bit gaps_on = 1'b0;
  // runs handed out so far, used to aim frees at live allocations
  int live_first [$];
  int live_len [$];

  bitmap_page_allocator_top #(.MAX_PAGES(MAX_PAGES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result words
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("bitmap_page_allocator_top_test: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // hand one command word to the block, after an optional gap
  task automatic send_cmd(input bpa_cmd_t c);
    int gap;
    bpa_result_t predicted;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      cmd <= bpa_cmd_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predicted = sb.note_cmd(c);
    if (c.kind == KIND_ALLOC && predicted.success) begin
      live_first.push_back(int'(predicted.first_page));
      live_len.push_back(int'(c.page_count));
      if (live_first.size() > 200) begin
        void'(live_first.pop_front());
        void'(live_len.pop_front());
      end
    end
  endtask

  task automatic directed(input logic k, input int count, input int first);
    bpa_cmd_t c;
    c.kind = k;
    c.page_count = PAGE_W'(count);
    c.start_page = FIELD_W'(first);
    send_cmd(c);
  endtask

  // stop sending and wait for every awaited word and an idle block
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // apb transfer: setup phase, then access until pready
  task automatic apb_access(input logic wr, input logic [PAGE_W-1:0] value,
                            output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= TOTAL_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_total(input logic [PAGE_W-1:0] value);
    logic [31:0] rd;
    drain_results();
    apb_access(1'b1, value, rd);
    sb.total_pages = value;
    apb_access(1'b0, '0, rd);
    if (rd !== 32'(value))
      sb.flag_mismatch($sformatf("page total reads %0d, written %0d", rd, value));
  endtask

  // random command shaped around the active page total
  function automatic bpa_cmd_t draw_cmd(input int eff);
    bpa_cmd_t c;
    int pick;
    int idx;
    int span;
    c.start_page = FIELD_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    span = (eff > 6) ? eff / 6 : 1;
    if (pick < 50) begin
      c.kind = KIND_ALLOC;
      if ($urandom_range(0, 9) == 0)
        c.page_count = PAGE_W'($urandom_range(1, (eff > 1) ? eff : 1));
      else
        c.page_count = PAGE_W'($urandom_range(1, span));
    end else if (pick < 85) begin
      c.kind = KIND_FREE;
      if (live_first.size() > 0) begin
        idx = $urandom_range(0, live_first.size() - 1);
        c.start_page = FIELD_W'(live_first[idx]);
        c.page_count = PAGE_W'(live_len[idx] +
                               (($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 0));
        live_first.delete(idx);
        live_len.delete(idx);
      end else begin
        c.start_page = FIELD_W'($urandom_range(0, (eff > 0) ? eff - 1 : 0));
        c.page_count = PAGE_W'($urandom_range(1, span));
      end
    end else begin
      // noise over the whole field ranges
      c.kind = $urandom_range(0, 1) ? KIND_FREE : KIND_ALLOC;
      c.page_count = PAGE_W'($urandom_range(0, 1) ? $urandom_range(0, 2047)
                                                   : $urandom_range(0, 4));
    end
    return c;
  endfunction

  initial begin
    int ph;
    int n;
    int tot;
    int eff;
    logic [31:0] rd;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // page total after reset, read during the clearing pass
    apb_access(1'b0, '0, rd);
    if (rd !== 32'(TOTAL_RESET))
      sb.flag_mismatch($sformatf("page total after reset reads %0d", rd));

    // directed: full map, zero and oversize counts, frees at the edges
    directed(KIND_ALLOC, 0, 0);
    directed(KIND_ALLOC, 1, 1023);
    directed(KIND_ALLOC, 2047, 0);
    directed(KIND_ALLOC, 1024, 0);
    directed(KIND_ALLOC, 1022, 0);
    directed(KIND_ALLOC, 1, 0);
    directed(KIND_ALLOC, 1, 0);
    directed(KIND_FREE, 2047, 1023);
    directed(KIND_FREE, 1, 0);
    directed(KIND_FREE, 3, 5);
    directed(KIND_ALLOC, 2, 0);
    directed(KIND_ALLOC, 2, 0);
    directed(KIND_ALLOC, 1, 0);
    directed(KIND_FREE, 2047, 0);
    directed(KIND_ALLOC, 1023, 0);
    // total above capacity acts as the capacity
    set_total(11'd2047);
    directed(KIND_FREE, 1, 1023);
    directed(KIND_ALLOC, 1, 0);
    directed(KIND_FREE, 1024, 0);
    // totals of one and zero
    set_total(11'd1);
    directed(KIND_ALLOC, 1, 0);
    directed(KIND_FREE, 1, 0);
    directed(KIND_FREE, 1, 1);
    set_total(11'd0);
    directed(KIND_ALLOC, 1, 0);
    directed(KIND_FREE, 1, 0);
    set_total(11'd2);
    directed(KIND_ALLOC, 1, 0);
    directed(KIND_ALLOC, 1, 0);
    directed(KIND_FREE, 1, 1);

    // random phases, each under its own page total
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: tot = 2047;
        1: tot = 0;
        2: tot = 1;
        3: tot = 2;
        4: tot = 1025;
        5: tot = 1024;
        default: tot = $urandom_range(0, 1) ? $urandom_range(3, 64)
                                            : $urandom_range(65, 1024);
      endcase
      set_total(PAGE_W'(tot));
      eff = (tot > MAX_PAGES) ? MAX_PAGES : tot;
      gaps_on = (ph % 4 != 3);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 29) == 0) drain_results();
        send_cmd(draw_cmd(eff));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d result words never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("bitmap_page_allocator_top_test: clean");
    end else begin
      $display("bitmap_page_allocator_top_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_lane_unit.sv
sv/bitmap_page_allocator_top.sv
tb/bitmap_page_allocator_top_test.sv
